// File: sv/integer_literal_parser_macros.svh
// Assertion helpers shared by the parser RTL.
`ifndef INTEGER_LITERAL_PARSER_MACROS_SVH
`define INTEGER_LITERAL_PARSER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ILP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ILP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ilp_pkg.sv
package ilp_pkg;

	// Width of the result value on the output stream.
	localparam int OUT_BITS = 64;

	// Parse phase, one-hot.
	typedef enum logic [4:0] {
		PH_START  = 5'b00001,
		PH_SIGNED = 5'b00010,
		PH_ZERO   = 5'b00100,
		PH_DIGITS = 5'b01000,
		PH_SUFFIX = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_HEX = 2'd1,
		RADIX_BIN = 2'd2
	} radix_t;

	typedef enum logic [1:0] {
		SUF_NONE = 2'd0,
		SUF_K    = 2'd1,
		SUF_M    = 2'd2
	} suffix_t;

	// Characters with a meaning of their own.
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_LO_X    = 8'h78;
	localparam logic [7:0] CH_LO_B    = 8'h62;
	localparam logic [7:0] CH_LO_A    = 8'h61;
	localparam logic [7:0] CH_LO_F    = 8'h66;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_F    = 8'h46;
	localparam logic [7:0] CH_UP_K    = 8'h4B;
	localparam logic [7:0] CH_UP_M    = 8'h4D;

	// Bit 4 flags a hex digit character, bits 3:0 hold its value.
	function automatic logic [4:0] ilp_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			r = {1'b1, 4'(c - CH_ZERO)};
		end else if (c >= CH_LO_A && c <= CH_LO_F) begin
			r = {1'b1, 4'(c - CH_LO_A + 8'd10)};
		end else if (c >= CH_UP_A && c <= CH_UP_F) begin
			r = {1'b1, 4'(c - CH_UP_A + 8'd10)};
		end
		return r;
	endfunction

endpackage

// File: sv/integer_literal_parser.sv
// A result is registered as the terminating zero leaves the character register, which
// feeds the parse logic. Throughput: one character per cycle, save that a terminator
// waits for a free result slot; the result register holds a finished value while new
// characters keep arriving. Reset: arst_n is asynchronous and active low; it clears the
// parse state and both valid flags, leaving the block ready for the start of a literal.
module integer_literal_parser
	import ilp_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [7:0] ch
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic signed [OUT_BITS-1:0] m_tdata,   // [63:0] value
	output logic [0:0]                 m_tuser    // [0] status
);

	localparam int WIDE_BITS = VALUE_BITS + 4;
	localparam int SCL_BITS  = VALUE_BITS + 17;
	localparam logic [VALUE_BITS-1:0] CAP     = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [VALUE_BITS-1:0] POS_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

	logic                  s1_valid_q;
	logic [7:0]            ch_s1;
	phase_t                phase_q, phase_d;
	radix_t                radix_q, radix_d, eff_radix;
	suffix_t               suffix_q, suffix_d;
	logic                  neg_q, neg_d;
	logic                  bad_q, bad_d;
	logic [VALUE_BITS-1:0] acc_q, acc_d;

	logic                  out_free, is_term, fire;
	logic [4:0]            dig;
	logic                  dig_ok, is_km;
	logic [WIDE_BITS-1:0]  acc_ext, dig_ext, acc_wide;
	logic [VALUE_BITS-1:0] acc_sat;
	phase_t                dstep_phase;
	suffix_t               dstep_suffix;
	logic                  dstep_bad;
	logic [VALUE_BITS-1:0] dstep_acc;

	logic                  fin_bad;
	logic [SCL_BITS-1:0]   scl_wide;
	logic [VALUE_BITS-1:0] mag, v_res;
	logic signed [OUT_BITS-1:0] v_ext;

	// Handshake: a character may wait in the input stage only for a free result slot.
	assign out_free = !m_tvalid || m_tready;
	assign is_term  = (ch_s1 == CH_NUL);
	assign fire     = s1_valid_q && (!is_term || out_free);
	assign s_tready = !s1_valid_q || fire;

	// Input character register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1 <= s_tdata;
		end
	end

	// Digit classification; before the digit run starts, digits are decimal.
	assign dig       = ilp_digit(ch_s1);
	assign eff_radix = (phase_q == PH_DIGITS) ? radix_q : RADIX_DEC;
	assign is_km     = (ch_s1 == CH_UP_K) || (ch_s1 == CH_UP_M);
	assign acc_ext   = {4'b0, acc_q};
	assign dig_ext   = WIDE_BITS'(dig[3:0]);

	// Accumulate one digit with saturation at the magnitude cap.
	always_comb begin
		unique case (eff_radix)
			RADIX_DEC: begin
				dig_ok   = dig[4] && (dig[3:0] < 4'd10);
				acc_wide = (acc_ext << 3) + (acc_ext << 1) + dig_ext;
			end
			RADIX_HEX: begin
				dig_ok   = dig[4];
				acc_wide = (acc_ext << 4) + dig_ext;
			end
			RADIX_BIN: begin
				dig_ok   = dig[4] && (dig[3:0] < 4'd2);
				acc_wide = (acc_ext << 1) + dig_ext;
			end
			default: begin
				dig_ok   = 1'b0;
				acc_wide = acc_ext;
			end
		endcase
		acc_sat = (acc_wide > {4'b0, CAP}) ? CAP : acc_wide[VALUE_BITS-1:0];
	end

	// Outcome of a character in digit position: digit, decimal suffix or error.
	always_comb begin
		dstep_acc    = acc_q;
		dstep_phase  = PH_DIGITS;
		dstep_suffix = suffix_q;
		dstep_bad    = 1'b0;
		if (dig_ok) begin
			dstep_acc = acc_sat;
		end else if (eff_radix == RADIX_DEC && is_km) begin
			dstep_phase  = PH_SUFFIX;
			dstep_suffix = (ch_s1 == CH_UP_K) ? SUF_K : SUF_M;
		end else begin
			dstep_bad = 1'b1;
		end
	end

	// Next parse state.
	always_comb begin
		phase_d  = phase_q;
		radix_d  = radix_q;
		suffix_d = suffix_q;
		neg_d    = neg_q;
		bad_d    = bad_q;
		acc_d    = acc_q;
		if (fire) begin
			if (is_term) begin
				phase_d  = PH_START;
				radix_d  = RADIX_DEC;
				suffix_d = SUF_NONE;
				neg_d    = 1'b0;
				bad_d    = 1'b0;
				acc_d    = '0;
			end else if (!bad_q) begin
				unique case (phase_q)
					PH_START, PH_SIGNED: begin
						priority if (phase_q == PH_START && ch_s1 == CH_MINUS) begin
							neg_d   = 1'b1;
							phase_d = PH_SIGNED;
						end else if (ch_s1 == CH_ZERO) begin
							phase_d = PH_ZERO;
						end else if (ch_s1 == CH_DOLLAR) begin
							radix_d = RADIX_HEX;
							phase_d = PH_DIGITS;
						end else if (ch_s1 == CH_PERCENT) begin
							radix_d = RADIX_BIN;
							phase_d = PH_DIGITS;
						end else begin
							radix_d  = RADIX_DEC;
							phase_d  = dstep_phase;
							suffix_d = dstep_suffix;
							bad_d    = dstep_bad;
							acc_d    = dstep_acc;
						end
					end
					PH_ZERO: begin
						priority if (ch_s1 == CH_LO_X) begin
							radix_d = RADIX_HEX;
							phase_d = PH_DIGITS;
						end else if (ch_s1 == CH_LO_B) begin
							radix_d = RADIX_BIN;
							phase_d = PH_DIGITS;
						end else if (dig_ok) begin
							radix_d = RADIX_DEC;
							phase_d = PH_DIGITS;
							acc_d   = acc_sat;
						end else begin
							bad_d = 1'b1;
						end
					end
					PH_DIGITS: begin
						phase_d  = dstep_phase;
						suffix_d = dstep_suffix;
						bad_d    = dstep_bad;
						acc_d    = dstep_acc;
					end
					default: begin
						bad_d = 1'b1;
					end
				endcase
			end
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			radix_q  <= RADIX_DEC;
			suffix_q <= SUF_NONE;
			neg_q    <= 1'b0;
			bad_q    <= 1'b0;
			acc_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			radix_q  <= radix_d;
			suffix_q <= suffix_d;
			neg_q    <= neg_d;
			bad_q    <= bad_d;
			acc_q    <= acc_d;
		end
	end

	// Final value: suffix scaling with saturation, then sign and clamp.
	assign fin_bad = bad_q || (phase_q == PH_START) || (phase_q == PH_SIGNED);

	always_comb begin
		unique case (suffix_q)
			SUF_K:   scl_wide = {7'b0, acc_q, 10'b0};
			SUF_M:   scl_wide = {acc_q, 17'b0};
			default: scl_wide = {17'b0, acc_q};
		endcase
		mag = (scl_wide > {17'b0, CAP}) ? CAP : scl_wide[VALUE_BITS-1:0];
		if (neg_q) begin
			v_res = '0 - mag;
		end else begin
			v_res = mag[VALUE_BITS-1] ? POS_MAX : mag;
		end
		v_ext = OUT_BITS'(signed'(v_res));
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (fire && is_term) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_term) begin
			m_tdata    <= fin_bad ? '0 : v_ext;
			m_tuser[0] <= fin_bad;
		end
	end

`include "integer_literal_parser_macros.svh"

	`ILP_ASSERT_IMP(a_acc_capped, 1'b1, acc_q <= CAP, "accumulator above magnitude cap")
	`ILP_ASSERT_NXT(a_clear_after_term, fire && is_term, phase_q == PH_START && !bad_q && acc_q == '0, "state not cleared after terminator")
	`ILP_ASSERT_IMP(a_bad_is_zero, m_tvalid && m_tuser[0], m_tdata == '0, "malformed result with nonzero value")
	`ILP_ASSERT_IMP(a_result_source, $rose(m_tvalid), $past(fire && is_term), "result without terminator")

endmodule

// File: dv/tb_integer_literal_parser.sv
module tb_integer_literal_parser;
	import ilp_pkg::*;

	localparam int VALUE_BITS = 64;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_CHARS = 1030;

	// Magnitude ceiling and the multipliers the parser applies.
	localparam logic [63:0] MAG_CAP = 64'd1 << (VALUE_BITS - 1);
	localparam logic [63:0] DEC_BASE = 64'd10;
	localparam logic [63:0] BIN_BASE = 64'd2;
	localparam logic [63:0] HEX_BASE = 64'h10;
	localparam logic [63:0] SCALE_K = 64'h400;
	localparam logic [63:0] SCALE_M = 64'h20000;

	// Status codes on the result stream.
	localparam logic ST_OK = 1'b0;
	localparam logic ST_MALFORMED = 1'b1;

	typedef struct packed {
		logic [63:0] value;
		logic        status;
	} parse_result_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic signed [63:0] m_tdata;
	logic [0:0]        m_tuser;

	// Shadow of the parser state, advanced on every accepted character.
	phase_t      pr_phase;
	logic        pr_neg;
	radix_t      pr_radix;
	logic [63:0] pr_mag;
	suffix_t     pr_suffix;
	logic        pr_bad;

	parse_result_t expected_results[$];
	logic [7:0]    lit_q[$];

	int cycles;
	int mismatches;
	int burst_left;
	int hold_cycles;
	int n_chars;
	int n_literals;
	int n_results;
	int n_malformed;

	integer_literal_parser #(
		.VALUE_BITS(VALUE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit, counted in clock cycles.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still pending", cycles,
				expected_results.size());
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] want,
		input logic [63:0] got);
		$display("[cycle %0d] %s: expected %h, got %h", cycles, what, want, got);
		mismatches++;
	endtask

	// Digit value of c in radix r, or -1 when c is not a digit of that radix.
	function automatic int digit_value(input logic [7:0] c, input radix_t r);
		int d;
		d = -1;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = int'(c - CH_ZERO);
		end else if (c >= CH_LO_A && c <= CH_LO_F) begin
			d = int'(c - CH_LO_A) + 10;
		end else if (c >= CH_UP_A && c <= CH_UP_F) begin
			d = int'(c - CH_UP_A) + 10;
		end
		if (r == RADIX_DEC && d >= 10) d = -1;
		if (r == RADIX_BIN && d >= 2) d = -1;
		return d;
	endfunction

	// Multiply and add, saturating at the magnitude ceiling.
	function automatic logic [63:0] cap_scale(input logic [63:0] m, input logic [63:0] k,
		input logic [63:0] add);
		if (m > (MAG_CAP - add) / k) return MAG_CAP;
		return m * k + add;
	endfunction

	task automatic clear_parse_state();
		pr_phase = PH_START;
		pr_neg = 1'b0;
		pr_radix = RADIX_DEC;
		pr_mag = '0;
		pr_suffix = SUF_NONE;
		pr_bad = 1'b0;
	endtask

	// A character inside the digit run: digit, decimal suffix, or leftover.
	task automatic take_digit(input logic [7:0] c);
		int d;
		logic [63:0] base;
		d = digit_value(c, pr_radix);
		base = (pr_radix == RADIX_HEX) ? HEX_BASE : ((pr_radix == RADIX_BIN) ? BIN_BASE : DEC_BASE);
		if (d >= 0) begin
			pr_mag = cap_scale(pr_mag, base, 64'(d));
		end else if (pr_radix == RADIX_DEC && (c == CH_UP_K || c == CH_UP_M)) begin
			pr_suffix = (c == CH_UP_K) ? SUF_K : SUF_M;
			pr_phase = PH_SUFFIX;
		end else begin
			pr_bad = 1'b1;
		end
	endtask

	// First character after the optional sign.
	task automatic take_lead(input logic [7:0] c);
		if (c == CH_ZERO) begin
			pr_phase = PH_ZERO;
		end else if (c == CH_DOLLAR) begin
			pr_radix = RADIX_HEX;
			pr_phase = PH_DIGITS;
		end else if (c == CH_PERCENT) begin
			pr_radix = RADIX_BIN;
			pr_phase = PH_DIGITS;
		end else begin
			pr_radix = RADIX_DEC;
			pr_phase = PH_DIGITS;
			take_digit(c);
		end
	endtask

	// Advance the shadow state by one character; the terminator yields a result.
	task automatic parse_char(input logic [7:0] c);
		parse_result_t r;
		logic [63:0] m;
		logic malformed;
		if (c == CH_NUL) begin
			malformed = pr_bad || pr_phase == PH_START || pr_phase == PH_SIGNED;
			m = pr_mag;
			if (pr_suffix == SUF_K) begin
				m = cap_scale(m, SCALE_K, 64'd0);
			end else if (pr_suffix == SUF_M) begin
				m = cap_scale(m, SCALE_M, 64'd0);
			end
			if (pr_neg) begin
				r.value = 64'd0 - m;
			end else begin
				r.value = (m > MAG_CAP - 64'd1) ? MAG_CAP - 64'd1 : m;
			end
			if (malformed) begin
				r.value = '0;
				r.status = ST_MALFORMED;
				n_malformed++;
			end else begin
				r.status = ST_OK;
			end
			expected_results.push_back(r);
			clear_parse_state();
		end else if (!pr_bad) begin
			case (pr_phase)
				PH_START: begin
					if (c == CH_MINUS) begin
						pr_neg = 1'b1;
						pr_phase = PH_SIGNED;
					end else begin
						take_lead(c);
					end
				end
				PH_SIGNED: begin
					take_lead(c);
				end
				PH_ZERO: begin
					if (c == CH_LO_X) begin
						pr_radix = RADIX_HEX;
						pr_phase = PH_DIGITS;
					end else if (c == CH_LO_B) begin
						pr_radix = RADIX_BIN;
						pr_phase = PH_DIGITS;
					end else if (c >= CH_ZERO && c <= CH_NINE) begin
						pr_radix = RADIX_DEC;
						pr_phase = PH_DIGITS;
						take_digit(c);
					end else begin
						pr_bad = 1'b1;
					end
				end
				PH_DIGITS: begin
					take_digit(c);
				end
				default: begin
					pr_bad = 1'b1;
				end
			endcase
		end
	endtask

	// Send one character as a beat; the sender may idle between random bursts.
	task automatic send_char(input logic [7:0] c);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= c;
		do @(posedge clk); while (!s_tready);
		parse_char(c);
		n_chars++;
	endtask

	task automatic send_literal();
		foreach (lit_q[i]) send_char(lit_q[i]);
		send_char(CH_NUL);
		n_literals++;
	endtask

	// Drop valid and wait until every pending result has been checked.
	task automatic wait_all_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] hex_char(input int v);
		if (v < 10) return CH_ZERO + 8'(v);
		return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + 8'(v - 10);
	endfunction

	task automatic push_sign();
		if ($urandom_range(0, 1)) lit_q.push_back(CH_MINUS);
	endtask

	// Mostly well-formed decimal, with optional leading zero and size suffix; it may hold no digits.
	task automatic build_decimal(input int max_digits);
		int n;
		push_sign();
		if ($urandom_range(0, 9) == 0) lit_q.push_back(CH_ZERO);
		n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, max_digits);
		repeat (n) lit_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
		case ($urandom_range(0, 7))
			0: lit_q.push_back(CH_UP_K);
			1: lit_q.push_back(CH_UP_M);
			default: ;
		endcase
	endtask

	task automatic build_hex();
		int n;
		push_sign();
		if ($urandom_range(0, 1)) begin
			lit_q.push_back(CH_ZERO);
			lit_q.push_back(CH_LO_X);
		end else begin
			lit_q.push_back(CH_DOLLAR);
		end
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 8);
		repeat (n) lit_q.push_back(hex_char($urandom_range(0, 15)));
	endtask

	task automatic build_binary();
		int n;
		push_sign();
		if ($urandom_range(0, 1)) begin
			lit_q.push_back(CH_ZERO);
			lit_q.push_back(CH_LO_B);
		end else begin
			lit_q.push_back(CH_PERCENT);
		end
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
		repeat (n) lit_q.push_back(CH_ZERO + 8'($urandom_range(0, 1)));
	endtask

	// Pick a literal shape: mostly well formed, some broken, some pure noise.
	task automatic build_literal();
		int kind;
		int pos;
		lit_q.delete();
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			build_decimal(8);
		end else if (kind < 48) begin
			build_hex();
		end else if (kind < 62) begin
			build_binary();
		end else if (kind < 68) begin
			build_decimal(24);
		end else if (kind < 88) begin
			// Well-formed literal with one character replaced or inserted.
			case ($urandom_range(0, 2))
				0: build_decimal(8);
				1: build_hex();
				default: build_binary();
			endcase
			pos = $urandom_range(0, lit_q.size());
			if (pos < lit_q.size() && $urandom_range(0, 1)) begin
				lit_q[pos] = 8'($urandom_range(1, 255));
			end else begin
				lit_q.insert(pos, 8'($urandom_range(1, 255)));
			end
		end else begin
			repeat ($urandom_range(0, 5)) lit_q.push_back(8'($urandom_range(1, 255)));
		end
	endtask

	// Receiver: long hold-off on request, otherwise a ready pattern of its own.
	initial begin
		int mode;
		int stretch;
		m_tready = 1'b0;
		mode = 0;
		stretch = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else begin
				if (stretch == 0) begin
					mode = $urandom_range(0, 2);
					stretch = $urandom_range(8, 80);
				end
				stretch--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Compare each result beat with the oldest pending expectation.
	always @(posedge clk) begin
		parse_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (expected_results.size() == 0) begin
				report_mismatch("result with no literal pending", '0, m_tdata);
			end else begin
				e = expected_results.pop_front();
				if (m_tdata !== e.value) report_mismatch("value", e.value, m_tdata);
				if (m_tuser[0] !== e.status) report_mismatch("status", 64'(e.status), 64'(m_tuser));
			end
		end
	end

	// Edge cases: empty input, bare sign, prefixes, suffixes, leftovers, saturation.
	task automatic test_directed_cases();
		string cases[$];
		cases = '{"", "-", "0", "-0", "007", "0q", "0K", "0x", "%", "0xFfa1",
			"$7fffffffffffffff", "$8000000000000000", "-$8000000000000000", "0b101", "%2",
			"12K", "-3M", "K", "-M", "1KK", " 5", "+5", "--5", "0x0x1",
			"99999999999999999999", "-9223372036854775807M", "\377"};
		foreach (cases[i]) begin
			lit_q.delete();
			for (int j = 0; j < cases[i].len(); j++) lit_q.push_back(cases[i][j]);
			send_literal();
		end
		wait_all_results();
	endtask

	// Results back up behind a stalled receiver until the input side stalls too.
	task automatic test_output_backpressure();
		hold_cycles = 250;
		repeat (40) begin
			lit_q.delete();
			build_decimal(3);
			send_literal();
		end
		wait_all_results();
	endtask

	// Random literals, with a full drain every so often.
	task automatic test_random_literals();
		int start;
		int count;
		start = n_chars;
		count = 0;
		while (n_chars - start < RANDOM_CHARS) begin
			build_literal();
			send_literal();
			count++;
			if (count % 60 == 0) wait_all_results();
		end
		wait_all_results();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		hold_cycles = 0;
		burst_left = 0;
		clear_parse_state();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_output_backpressure();
		test_random_literals();

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Parsed %0d literals (%0d characters), %0d flagged malformed.",
			n_literals, n_chars, n_malformed);
		$display("Checked %0d results in %0d cycles, %0d mismatches.",
			n_results, cycles, mismatches);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
